/* rtl/mpe_pkg.sv */
// Shared types and constants for the matrix power engine.
// Used by mpe_datapath, mpe_ctrl and the top module in rtl/; depends on nothing.
`default_nettype none

package mpe_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned SIZE_W = 4;
   localparam int unsigned EXP_W  = 8;
   localparam int unsigned CSR_AW = 1;

   localparam logic [CSR_AW-1:0] CSR_SIZE_IN_USE = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_EXPONENT    = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
   localparam logic [EXP_W-1:0]  EXP_RESET  = 8'd2;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PLAN,
      ST_ROUND,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_HOLD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_we;
      logic load_start;
      logic iter_clear;
      logic iter_step;
      logic bank_flip;
      logic round_dec;
      logic emit_clear;
      logic emit_read;
      logic emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_complete;
      logic iter_last;
      logic pipe_busy;
      logic rounds_zero;
      logic emit_last;
   } status_type;

endpackage

`default_nettype wire

/* rtl/mpe_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the base and power matrix stores.
`default_nettype none

module mpe_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/mpe_datapath.sv */
// Datapath of the matrix power engine: CSRs, load counter, matrix stores,
// multiply-accumulate pipeline and output read. Depends on mpe_pkg, mpe_ram.
`default_nettype none

module mpe_datapath #(
   parameter int unsigned MAX_DIM = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [mpe_pkg::CSR_AW-1:0]      csr_addr,
   input  wire logic [mpe_pkg::EXP_W-1:0]       csr_wdata,
   input  wire logic [mpe_pkg::DATA_W-1:0]      req_element,
   input  wire mpe_pkg::cmd_type                cmd,
   output mpe_pkg::status_type                  st,
   output logic      [mpe_pkg::DATA_W-1:0]      rsp_value
);

   localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
   localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int unsigned NW     = $clog2(MAX_DIM + 1);
   localparam int unsigned PDEPTH = 2 * (1 << IDX_W);

   localparam int unsigned DW = mpe_pkg::DATA_W;

   // Configuration registers.
   logic [mpe_pkg::SIZE_W-1:0] size_ff;
   logic [mpe_pkg::EXP_W-1:0]  exp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mpe_pkg::SIZE_RESET;
         exp_ff  <= mpe_pkg::EXP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            mpe_pkg::CSR_SIZE_IN_USE: size_ff <= csr_wdata[mpe_pkg::SIZE_W-1:0];
            mpe_pkg::CSR_EXPONENT:    exp_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Matrix dimension clamped to 1..MAX_DIM.
   logic [NW-1:0]    dim;
   logic [DIM_W-1:0] dim_m1;
   logic [CNT_W-1:0] cells;

   always_comb begin
      if (size_ff == '0) begin
         dim = NW'(1);
      end else if (size_ff > mpe_pkg::SIZE_W'(MAX_DIM)) begin
         dim = NW'(MAX_DIM);
      end else begin
         dim = NW'(size_ff);
      end
      dim_m1 = DIM_W'(dim - NW'(1));
      cells  = CNT_W'(dim) * CNT_W'(dim);
   end

   // Load counter.
   logic [CNT_W-1:0] load_count_ff;
   logic [CNT_W-1:0] load_next;

   assign load_next        = load_count_ff + CNT_W'(1);
   assign st.load_complete = (load_next >= cells);

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else if (cmd.load_we) begin
         load_count_ff <= st.load_complete ? '0 : load_next;
      end
   end

   // Rounds still to run.
   logic [mpe_pkg::EXP_W-1:0] rounds_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rounds_ff <= '0;
      end else if (cmd.load_start) begin
         rounds_ff <= (exp_ff > mpe_pkg::EXP_W'(1)) ? exp_ff - mpe_pkg::EXP_W'(1) : '0;
      end else if (cmd.round_dec) begin
         rounds_ff <= rounds_ff - mpe_pkg::EXP_W'(1);
      end
   end

   assign st.rounds_zero = (rounds_ff == '0);

   // Power store bank: the current power matrix lives in bank bank_ff.
   logic bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
      end else if (cmd.load_start) begin
         bank_ff <= 1'b0;
      end else if (cmd.bank_flip) begin
         bank_ff <= ~bank_ff;
      end
   end

   // Row, column and inner-product counters with running flat bases.
   logic [DIM_W-1:0] r_ff, c_ff, k_ff;
   logic [IDX_W-1:0] row_base_ff, k_base_ff;
   logic             k_end, c_end, r_end;

   assign k_end        = (k_ff == dim_m1);
   assign c_end        = (c_ff == dim_m1);
   assign r_end        = (r_ff == dim_m1);
   assign st.iter_last = k_end && c_end && r_end;

   always_ff @(posedge clock) begin
      if (reset || cmd.iter_clear) begin
         r_ff        <= '0;
         c_ff        <= '0;
         k_ff        <= '0;
         row_base_ff <= '0;
         k_base_ff   <= '0;
      end else if (cmd.iter_step) begin
         if (!k_end) begin
            k_ff      <= k_ff + DIM_W'(1);
            k_base_ff <= k_base_ff + IDX_W'(dim);
         end else begin
            k_ff      <= '0;
            k_base_ff <= '0;
            if (!c_end) begin
               c_ff <= c_ff + DIM_W'(1);
            end else begin
               c_ff        <= '0;
               r_ff        <= r_ff + DIM_W'(1);
               row_base_ff <= row_base_ff + IDX_W'(dim);
            end
         end
      end
   end

   // Output read index.
   logic [IDX_W-1:0] emit_idx_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.emit_clear) begin
         emit_idx_ff <= '0;
      end else if (cmd.emit_step) begin
         emit_idx_ff <= emit_idx_ff + IDX_W'(1);
      end
   end

   assign st.emit_last = ((CNT_W'(emit_idx_ff) + CNT_W'(1)) == cells);

   // Multiply-accumulate pipeline: read, multiply, accumulate and write back.
   logic             v1_ff, first1_ff, last1_ff;
   logic [IDX_W-1:0] wa1_ff;
   logic             v2_ff, first2_ff, last2_ff;
   logic [IDX_W-1:0] wa2_ff;
   logic [DW-1:0]    prod_ff, acc_ff, sum;
   logic [DW-1:0]    pow_rd, base_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.iter_step;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= (k_ff == '0);
      last1_ff  <= k_end;
      wa1_ff    <= row_base_ff + IDX_W'(c_ff);
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      wa2_ff    <= wa1_ff;
      prod_ff   <= pow_rd * base_rd;
      if (v2_ff) begin
         acc_ff <= sum;
      end
   end

   assign sum          = (first2_ff ? '0 : acc_ff) + prod_ff;
   assign st.pipe_busy = v1_ff || v2_ff;

   // Store ports.
   logic [IDX_W:0]   pow_wa, pow_ra;
   logic [DW-1:0]    pow_wd;
   logic             pow_we;

   always_comb begin
      if (cmd.load_we) begin
         pow_we = 1'b1;
         pow_wa = {1'b0, load_count_ff[IDX_W-1:0]};
         pow_wd = req_element;
      end else begin
         pow_we = v2_ff && last2_ff;
         pow_wa = {~bank_ff, wa2_ff};
         pow_wd = sum;
      end
      if (cmd.emit_read) begin
         pow_ra = {bank_ff, emit_idx_ff};
      end else begin
         pow_ra = {bank_ff, row_base_ff + IDX_W'(k_ff)};
      end
   end

   mpe_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH),
      .AW    (IDX_W)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (cmd.load_we),
      .wr_addr (load_count_ff[IDX_W-1:0]),
      .wr_data (req_element),
      .rd_en   (cmd.iter_step),
      .rd_addr (k_base_ff + IDX_W'(c_ff)),
      .rd_data (base_rd)
   );

   mpe_ram #(
      .WIDTH (DW),
      .DEPTH (PDEPTH),
      .AW    (IDX_W + 1)
   ) u_power_ram (
      .clock   (clock),
      .wr_en   (pow_we),
      .wr_addr (pow_wa),
      .wr_data (pow_wd),
      .rd_en   (cmd.iter_step || cmd.emit_read),
      .rd_addr (pow_ra),
      .rd_data (pow_rd)
   );

   assign rsp_value = pow_rd;

endmodule

`default_nettype wire

/* rtl/mpe_ctrl.sv */
// Controller state machine of the matrix power engine: load, multiply
// rounds, pipeline drain and result output. Depends on mpe_pkg.
`default_nettype none

module mpe_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output mpe_pkg::cmd_type         cmd,
   input  wire mpe_pkg::status_type st
);

   mpe_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpe_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         mpe_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_we = 1'b1;
               if (st.load_complete) begin
                  cmd.load_start = 1'b1;
                  cmd.iter_clear = 1'b1;
                  state_in       = mpe_pkg::ST_PLAN;
               end
            end
         end
         mpe_pkg::ST_PLAN: begin
            if (st.rounds_zero) begin
               cmd.emit_clear = 1'b1;
               state_in       = mpe_pkg::ST_EMIT_RD;
            end else begin
               state_in = mpe_pkg::ST_ROUND;
            end
         end
         mpe_pkg::ST_ROUND: begin
            cmd.iter_step = 1'b1;
            if (st.iter_last) begin
               state_in = mpe_pkg::ST_DRAIN;
            end
         end
         mpe_pkg::ST_DRAIN: begin
            // The new power matrix is complete once the last sum is written.
            if (!st.pipe_busy) begin
               cmd.bank_flip  = 1'b1;
               cmd.round_dec  = 1'b1;
               cmd.iter_clear = 1'b1;
               state_in       = mpe_pkg::ST_PLAN;
            end
         end
         mpe_pkg::ST_EMIT_RD: begin
            cmd.emit_read = 1'b1;
            state_in      = mpe_pkg::ST_EMIT_HOLD;
         end
         mpe_pkg::ST_EMIT_HOLD: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.emit_step = 1'b1;
               state_in      = st.emit_last ? mpe_pkg::ST_LOAD : mpe_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = mpe_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/matrix_power_engine_top.sv */
// Matrix power engine: loads an n x n matrix one element per cycle, then
// after the last element runs R = max(exponent-1, 0) multiply rounds
// (one multiply-accumulate per cycle, three-stage pipeline), then
// emits n*n results from the power store read port, each held until taken.
// Intake stalls from the last element until the final result is taken.
// Synchronous active-high reset: size 8, exponent 2, load empty; stores uncleared.
`default_nettype none

module matrix_power_engine_top #(
   parameter int unsigned MAX_DIM = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [mpe_pkg::CSR_AW-1:0] csr_addr,
   input  wire logic [mpe_pkg::EXP_W-1:0]  csr_wdata,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [31:0]                req_tdata,   // [31:0] element
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [31:0]                rsp_tdata,   // [31:0] value
   output logic                            rsp_tlast
);

   mpe_pkg::cmd_type    cmd;
   mpe_pkg::status_type st;

   mpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .st         (st)
   );

   mpe_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_element (req_tdata),
      .cmd         (cmd),
      .st          (st),
      .rsp_value   (rsp_tdata)
   );

   assign rsp_tlast = st.emit_last;

endmodule

`default_nettype wire
